@@ rtl/worst_fit_block_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the worst-fit block allocator
// Clocked property checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked at every rising clock edge outside reset.
`define WFBA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define WFBA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define WFBA_ASSERT(lbl, prop, msg)
`define WFBA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/wfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Worst-fit block allocator package
// Request kinds, response status codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package wfba_pkg;

   localparam int KIND_W   = 2;
   localparam int IDX_W    = 4;
   localparam int AMOUNT_W = 16;
   localparam int STATUS_W = 2;
   localparam int PLACED_W = 5;
   localparam int LEFT_W   = 16;
   localparam int TOTAL_W  = 20;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_LOAD  = 2'd0;
   localparam kind_type KIND_ALLOC = 2'd1;
   localparam kind_type KIND_FREE  = 2'd2;
   localparam kind_type KIND_RSVD  = 2'd3;

   localparam status_type STATUS_DONE       = 2'd0;
   localparam status_type STATUS_NO_FIT     = 2'd1;
   localparam status_type STATUS_NOT_PLACED = 2'd2;

endpackage

`default_nettype wire

@@ rtl/worst_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Worst-fit block allocator
// Tracks free space per memory block and the home block and size of each
// process; places processes in the block with the most free space.
// ----------------------------------------------------------------------------
// One request at a time. A load passes the decode and write states, a free
// or an allocate of an already placed process looks up the home block of the
// process and its free space, and an allocate that must search scans every
// block: the search reads the free-space memory through its single read port,
// one block per cycle, into one magnitude comparator. The next request is
// taken while the previous result still waits in the output register. Status
// 1 means no block has room; block_free_left then gives the largest free
// space. Status 2 means the process is out of range or not placed. total_free
// is the sum of free space after the request, kept as a running total.
`default_nettype none

module worst_fit_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int NUM_PROCS  = 16,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [wfba_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [wfba_pkg::IDX_W-1:0]     req_block_index,
   input  wire logic [wfba_pkg::IDX_W-1:0]     req_process_index,
   input  wire logic [wfba_pkg::AMOUNT_W-1:0]  req_amount,

   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [wfba_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [wfba_pkg::PLACED_W-1:0]  rsp_placed_block,
   output      logic [wfba_pkg::LEFT_W-1:0]    rsp_block_free_left,
   output      logic [wfba_pkg::TOTAL_W-1:0]   rsp_total_free
);

`include "worst_fit_block_allocator_assert.svh"

   localparam int BIDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int PIDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int BCNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int TOT_W  = SIZE_BITS + BIDX_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_LD_RD   = 4'd2;
   localparam logic [3:0] S_SCAN    = 4'd3;
   localparam logic [3:0] S_AL_DEC  = 4'd4;
   localparam logic [3:0] S_AL_HOME = 4'd5;
   localparam logic [3:0] S_AL_HFS  = 4'd6;
   localparam logic [3:0] S_FR_HOME = 4'd7;
   localparam logic [3:0] S_FR_ADD  = 4'd8;
   localparam logic [3:0] S_RESP    = 4'd9;

   // memories and their registered read data
   logic [SIZE_BITS-1:0] fs_mem [NUM_BLOCKS];
   logic [SIZE_BITS-1:0] ps_mem [NUM_PROCS];
   logic [BIDX_W-1:0]    ph_mem [NUM_PROCS];
   logic [SIZE_BITS-1:0] fs_q;
   logic                 fs_vld_q;
   logic [SIZE_BITS-1:0] ps_q;
   logic [BIDX_W-1:0]    ph_q;

   logic [NUM_BLOCKS-1:0] fs_vld_ff, fs_vld_in;
   logic [NUM_PROCS-1:0]  placed_ff, placed_in;

   logic [3:0]                      state_ff, state_in;
   logic [wfba_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [wfba_pkg::IDX_W-1:0]      blk_ff, blk_in;
   logic [wfba_pkg::IDX_W-1:0]      proc_ff, proc_in;
   logic [SIZE_BITS-1:0]            amt_ff, amt_in;
   logic [BCNT_W-1:0]               scan_idx_ff, scan_idx_in;
   logic [SIZE_BITS-1:0]            best_free_ff, best_free_in;
   logic [BIDX_W-1:0]               best_idx_ff, best_idx_in;
   logic [TOT_W-1:0]                total_ff, total_in;
   logic [wfba_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [wfba_pkg::PLACED_W-1:0]   res_block_ff, res_block_in;
   logic [wfba_pkg::LEFT_W-1:0]     res_left_ff, res_left_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wfba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [wfba_pkg::PLACED_W-1:0]   rsp_block_ff, rsp_block_in;
   logic [wfba_pkg::LEFT_W-1:0]     rsp_left_ff, rsp_left_in;
   logic [wfba_pkg::TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;

   logic                 fs_we;
   logic [BIDX_W-1:0]    fs_waddr;
   logic [SIZE_BITS-1:0] fs_wdata;
   logic [BIDX_W-1:0]    fs_raddr;
   logic                 proc_we;

   logic                 req_xfer;
   logic                 blk_ok;
   logic                 proc_ok;
   logic [BIDX_W-1:0]    blk_idx;
   logic [PIDX_W-1:0]    proc_idx;
   logic [SIZE_BITS-1:0] fs_eff;
   logic [SIZE_BITS:0]   ret_sum;
   logic [SIZE_BITS-1:0] ret_sat;
   logic [BCNT_W-1:0]    cmp_idx;
   logic [BIDX_W:0]      home_p1;
   logic [BIDX_W:0]      best_p1;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign blk_idx  = BIDX_W'(blk_ff);
   assign proc_idx = PIDX_W'(proc_ff);
   assign blk_ok   = (32'(blk_ff) < NUM_BLOCKS);
   assign proc_ok  = (32'(proc_ff) < NUM_PROCS);
   assign fs_eff   = fs_vld_q ? fs_q : '0;
   assign ret_sum  = {1'b0, fs_eff} + {1'b0, ps_q};
   assign ret_sat  = ret_sum[SIZE_BITS] ? '1 : ret_sum[SIZE_BITS-1:0];
   assign cmp_idx  = scan_idx_ff - BCNT_W'(1);
   assign home_p1  = {1'b0, ph_q} + (BIDX_W+1)'(1);
   assign best_p1  = {1'b0, best_idx_ff} + (BIDX_W+1)'(1);

   always_comb begin
      unique case (state_ff)
         S_DECODE: fs_raddr = blk_idx;
         S_SCAN:   fs_raddr = scan_idx_ff[BIDX_W-1:0];
         default:  fs_raddr = ph_q;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      blk_in        = blk_ff;
      proc_in       = proc_ff;
      amt_in        = amt_ff;
      scan_idx_in   = scan_idx_ff;
      best_free_in  = best_free_ff;
      best_idx_in   = best_idx_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_left_in   = res_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_total_in  = rsp_total_ff;
      fs_vld_in     = fs_vld_ff;
      placed_in     = placed_ff;
      fs_we         = 1'b0;
      fs_waddr      = blk_idx;
      fs_wdata      = amt_ff;
      proc_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_kind;
               blk_in   = req_block_index;
               proc_in  = req_process_index;
               amt_in   = SIZE_BITS'(req_amount);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_status_in = wfba_pkg::STATUS_DONE;
            res_block_in  = '0;
            res_left_in   = '0;
            state_in      = S_RESP;
            unique if (kind_ff == wfba_pkg::KIND_LOAD) begin
               if (blk_ok) begin
                  state_in = S_LD_RD;
               end
            end else if (kind_ff == wfba_pkg::KIND_ALLOC) begin
               if (!proc_ok) begin
                  res_status_in = wfba_pkg::STATUS_NOT_PLACED;
               end else if (placed_ff[proc_idx]) begin
                  state_in = S_AL_HOME;
               end else begin
                  scan_idx_in = '0;
                  state_in    = S_SCAN;
               end
            end else if (kind_ff == wfba_pkg::KIND_FREE) begin
               if (!proc_ok || !placed_ff[proc_idx]) begin
                  res_status_in = wfba_pkg::STATUS_NOT_PLACED;
               end else begin
                  state_in = S_FR_HOME;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_LD_RD: begin
            fs_we              = 1'b1;
            fs_vld_in[blk_idx] = 1'b1;
            total_in           = total_ff - TOT_W'(fs_eff) + TOT_W'(amt_ff);
            res_block_in       = wfba_pkg::PLACED_W'(blk_ff) + wfba_pkg::PLACED_W'(1);
            res_left_in        = wfba_pkg::LEFT_W'(amt_ff);
            state_in           = S_RESP;
         end
         S_SCAN: begin
            scan_idx_in = scan_idx_ff + BCNT_W'(1);
            // read data arrives in the cycle after its address is given
            if (scan_idx_ff == BCNT_W'(1)) begin
               best_free_in = fs_eff;
               best_idx_in  = cmp_idx[BIDX_W-1:0];
            end else if (scan_idx_ff != '0 && fs_eff > best_free_ff) begin
               best_free_in = fs_eff;
               best_idx_in  = cmp_idx[BIDX_W-1:0];
            end
            if (scan_idx_ff == BCNT_W'(NUM_BLOCKS)) begin
               state_in = S_AL_DEC;
            end
         end
         S_AL_DEC: begin
            if (amt_ff > best_free_ff) begin
               res_status_in = wfba_pkg::STATUS_NO_FIT;
               res_left_in   = wfba_pkg::LEFT_W'(best_free_ff);
            end else begin
               fs_we                   = 1'b1;
               fs_waddr                = best_idx_ff;
               fs_wdata                = best_free_ff - amt_ff;
               fs_vld_in[best_idx_ff]  = 1'b1;
               proc_we                 = 1'b1;
               placed_in[proc_idx]     = 1'b1;
               total_in                = total_ff - TOT_W'(amt_ff);
               res_block_in            = wfba_pkg::PLACED_W'(best_p1);
               res_left_in             = wfba_pkg::LEFT_W'(best_free_ff - amt_ff);
            end
            state_in = S_RESP;
         end
         S_AL_HOME: begin
            state_in = S_AL_HFS;
         end
         S_AL_HFS: begin
            res_block_in = wfba_pkg::PLACED_W'(home_p1);
            res_left_in  = wfba_pkg::LEFT_W'(fs_eff);
            state_in     = S_RESP;
         end
         S_FR_HOME: begin
            state_in = S_FR_ADD;
         end
         S_FR_ADD: begin
            fs_we               = 1'b1;
            fs_waddr            = ph_q;
            fs_wdata            = ret_sat;
            fs_vld_in[ph_q]     = 1'b1;
            placed_in[proc_idx] = 1'b0;
            total_in            = total_ff + TOT_W'(ret_sat - fs_eff);
            res_block_in        = wfba_pkg::PLACED_W'(home_p1);
            res_left_in         = wfba_pkg::LEFT_W'(ret_sat);
            state_in            = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               rsp_left_in   = res_left_ff;
               rsp_total_in  = wfba_pkg::TOTAL_W'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= fs_wdata;
      end
      fs_q     <= fs_mem[fs_raddr];
      fs_vld_q <= fs_vld_ff[fs_raddr];
   end

   always_ff @(posedge clock) begin
      if (proc_we) begin
         ps_mem[proc_idx] <= amt_ff;
         ph_mem[proc_idx] <= best_idx_ff;
      end
      ps_q <= ps_mem[proc_idx];
      ph_q <= ph_mem[proc_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fs_vld_ff    <= '0;
         placed_ff    <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fs_vld_ff    <= fs_vld_in;
         placed_ff    <= placed_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      blk_ff        <= blk_in;
      proc_ff       <= proc_in;
      amt_ff        <= amt_in;
      scan_idx_ff   <= scan_idx_in;
      best_free_ff  <= best_free_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_left_ff   <= res_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_placed_block    = rsp_block_ff;
   assign rsp_block_free_left = rsp_left_ff;
   assign rsp_total_free      = rsp_total_ff;

   `WFBA_ASSERT(a_xfer_to_decode, req_xfer |=> state_ff == S_DECODE, "transfer did not start decode")
   `WFBA_ASSERT(a_scan_unplaced, state_ff == S_SCAN |-> !placed_ff[proc_idx], "search for a placed process")
   `WFBA_ASSERT(a_scan_done, state_ff == S_AL_DEC |-> scan_idx_ff == BCNT_W'(NUM_BLOCKS + 1), "fit check before search end")
   `WFBA_ASSERT(a_resp_hold, state_ff == S_RESP && rsp_valid_ff && !rsp_ready |=> state_ff == S_RESP, "result register overwritten while stalled")
   `WFBA_ASSERT(a_nofit_none, rsp_valid_ff && rsp_status_ff == wfba_pkg::STATUS_NO_FIT |-> rsp_block_ff == '0, "no-fit result names a block")

endmodule

`default_nettype wire
